>>> rtl/rlfe_pkg.sv
// ----------------------------------------------------------------------------
// rlfe_pkg: shared types, codes and functions of the frame line encoder
// Command and result payloads, internal command codes, CRC table and the
// serial part packer.
// ----------------------------------------------------------------------------
package rlfe_pkg;

  // Input request payload
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } res_item_t;

  // Input function codes
  localparam logic [2:0] FUNC_START_BUF   = 3'd0;
  localparam logic [2:0] FUNC_START_FRAME = 3'd1;
  localparam logic [2:0] FUNC_FLAG        = 3'd2;
  localparam logic [2:0] FUNC_DATA        = 3'd3;
  localparam logic [2:0] FUNC_CRC         = 3'd4;
  localparam logic [2:0] FUNC_TAIL        = 3'd5;

  // Line modes; the byte mode is any code from MODE_BYTE upwards
  localparam logic [1:0] MODE_PULSE  = 2'd0;
  localparam logic [1:0] MODE_SERIAL = 2'd1;
  localparam logic [1:0] MODE_BYTE   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [0:0] REG_LINE_MODE = 1'd0;
  localparam logic [0:0] REG_PERIOD    = 1'd1;
  localparam logic [15:0] PERIOD_RESET = 16'd18000;

  // Line constants
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [5:0] PULSE_ONE   = 6'd47;
  localparam logic [5:0] PULSE_ZERO  = 6'd31;
  localparam logic [2:0] STUFF_RUN   = 3'd5;
  localparam logic [15:0] CRC_POLY_R = 16'h8408;

  // Command queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Classified command codes
  typedef enum logic [2:0] {
    OP_START_BUF   = 3'd0,
    OP_START_FRAME = 3'd1,
    OP_FLAG        = 3'd2,
    OP_DATA        = 3'd3,
    OP_CRC         = 3'd4,
    OP_TAIL        = 3'd5
  } op_t;

  // Classified command as held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Configuration as seen by the back end
  typedef struct packed {
    logic [1:0]  line_mode;
    logic [15:0] period;
  } cfg_t;

  // Serial packer outcome for one part
  typedef struct packed {
    logic [7:0] shift;
    logic [2:0] fill;
    logic       emit;
    logic [7:0] bval;
  } ser_t;

  // Reflected CRC table entry, eight shift steps
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

  // Byte-wise CRC update, MSB first with the reflected table
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    return {crc[7:0], 8'h00} ^ crc_table(crc[15:8] ^ b);
  endfunction

  // Pack one part (01 for zero, 001 for one) LSB first into the open byte
  function automatic ser_t serial_part(input logic [7:0] sh, input logic [2:0] fill,
                                       input logic one);
    ser_t r;
    logic b;
    logic act;
    r.shift = sh;
    r.fill  = fill;
    r.emit  = 1'b0;
    r.bval  = 8'h00;
    for (int i = 0; i < 3; i++) begin
      act = one || (i < 2);
      b   = one ? (i == 2) : (i == 1);
      if (act) begin
        r.shift = {b, r.shift[7:1]};
        r.fill  = r.fill + 3'd1;
        if (r.fill == 3'd0) begin
          r.emit = 1'b1;
          r.bval = r.shift;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/rlfe_front.sv
// ----------------------------------------------------------------------------
// rlfe_front: request intake and classification
// Registers one request, turns its function code into a command code, drops
// unused codes and pushes the command into the queue.
// ----------------------------------------------------------------------------
module rlfe_front import rlfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  in_item_t cmd,
  output logic     q_push,
  output cmd_t     q_item,
  input  logic     q_full
);

  logic f_valid;
  logic f_valid_next;
  cmd_t f_item;
  logic accept;
  logic known;
  op_t  op_dec;

  // Decode the function code
  always_comb begin
    known  = 1'b1;
    op_dec = OP_START_BUF;
    case (cmd.func)
      FUNC_START_BUF:   op_dec = OP_START_BUF;
      FUNC_START_FRAME: op_dec = OP_START_FRAME;
      FUNC_FLAG:        op_dec = OP_FLAG;
      FUNC_DATA:        op_dec = OP_DATA;
      FUNC_CRC:         op_dec = OP_CRC;
      FUNC_TAIL:        op_dec = OP_TAIL;
      default:          known  = 1'b0;
    endcase
  end

  // Hold while the queue is full
  assign cmd_stall    = f_valid && q_full;
  assign accept       = cmd_valid && !cmd_stall;
  assign f_valid_next = (f_valid && q_full) || (accept && known);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  // Capture the classified command
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.op   <= op_dec;
      f_item.data <= cmd.data_byte;
    end
  end

  assign q_push = f_valid;
  assign q_item = f_item;

endmodule

>>> rtl/rlfe_queue.sv
// ----------------------------------------------------------------------------
// rlfe_queue: command queue
// Short first-in first-out store between intake and execution.
// ----------------------------------------------------------------------------
module rlfe_queue import rlfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_item,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/rlfe_back.sv
// ----------------------------------------------------------------------------
// rlfe_back: command execution
// Holds CRC and line state, steps one line part per cycle unless stalled, and
// drives the result register. The newest result waits in a pending slot so
// that the final one of a request can be marked.
// ----------------------------------------------------------------------------
module rlfe_back import rlfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      state, state_next;
  op_t         op, op_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic [7:0]  next_byte, next_byte_next;
  logic        more, more_next;
  logic [3:0]  cnt, cnt_next;
  logic        stuff_pend, stuff_pend_next;
  logic        esc_second, esc_second_next;
  logic [15:0] crc_reg, crc_reg_next;
  logic [2:0]  ones_run, ones_run_next;
  logic [15:0] remainder, remainder_next;
  logic [5:0]  held_pulse, held_pulse_next;
  logic        held_valid, held_valid_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [2:0]  bit_fill, bit_fill_next;
  logic        pend_valid, pend_valid_next;
  logic [15:0] pend_word, pend_word_next;
  logic        out_valid, out_valid_next;
  logic [15:0] out_word, out_word_next;
  logic        out_last, out_last_next;

  logic        adv;
  logic        byte_mode;
  logic        emit;
  logic [15:0] emit_word;
  logic        part_req;
  logic        part_one;
  logic        done;
  logic        byte_done;
  logic        bit_val;
  logic [3:0]  cnt_m1;
  logic [2:0]  ones_inc;
  logic [5:0]  pulse_d;
  logic [15:0] pulse_cost;
  logic [16:0] tail_sum;
  logic [3:0]  pad_n;
  logic [15:0] pad_wide;
  ser_t        ser;

  assign adv       = !out_valid || !res_stall;
  assign byte_mode = (cfg.line_mode >= MODE_BYTE);
  assign cnt_m1    = cnt - 4'd1;
  assign bit_val   = cur_byte[cnt_m1[2:0]];
  assign ones_inc  = ones_run + 3'd1;
  assign pulse_d   = part_one ? PULSE_ONE : PULSE_ZERO;
  assign pulse_cost = 16'(pulse_d) + 16'd1;
  assign tail_sum  = {1'b0, remainder} + 17'(held_pulse);
  assign pad_n     = 4'd8 - 4'(bit_fill);
  assign pad_wide  = {8'hFF, shift_byte} >> pad_n;
  assign ser       = serial_part(shift_byte, bit_fill, part_one);

  always_comb begin
    state_next      = state;
    op_next         = op;
    cur_byte_next   = cur_byte;
    next_byte_next  = next_byte;
    more_next       = more;
    cnt_next        = cnt;
    stuff_pend_next = stuff_pend;
    esc_second_next = esc_second;
    crc_reg_next    = crc_reg;
    ones_run_next   = ones_run;
    remainder_next  = remainder;
    held_pulse_next = held_pulse;
    held_valid_next = held_valid;
    shift_byte_next = shift_byte;
    bit_fill_next   = bit_fill;
    pend_valid_next = pend_valid;
    pend_word_next  = pend_word;
    out_valid_next  = out_valid && res_stall;
    out_word_next   = out_word;
    out_last_next   = out_last;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_word = 16'h0000;
    part_req  = 1'b0;
    part_one  = 1'b0;
    done      = 1'b0;
    byte_done = 1'b0;

    case (state)
      // Take the next command and set it up
      ST_IDLE: begin
        if (adv && q_valid) begin
          q_pop   = 1'b1;
          op_next = q_head.op;
          cnt_next        = 4'd8;
          stuff_pend_next = 1'b0;
          esc_second_next = 1'b0;
          case (q_head.op)
            OP_START_BUF: begin
              ones_run_next   = 3'd0;
              held_valid_next = 1'b0;
              remainder_next  = cfg.period;
            end
            OP_START_FRAME: begin
              crc_reg_next = 16'h0000;
            end
            OP_FLAG: begin
              cnt_next   = 4'd0;
              state_next = ST_RUN;
            end
            OP_DATA: begin
              cur_byte_next = q_head.data;
              more_next     = 1'b0;
              crc_reg_next  = crc_update(crc_reg, q_head.data);
              state_next    = ST_RUN;
            end
            OP_CRC: begin
              cur_byte_next  = crc_reg[15:8];
              next_byte_next = crc_reg[7:0];
              more_next      = 1'b1;
              crc_reg_next   = crc_update(crc_reg, crc_reg[15:8]);
              state_next     = ST_RUN;
            end
            OP_TAIL: begin
              state_next = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end

      // One line step per cycle while the result port is not stalled
      ST_RUN: begin
        if (adv) begin
          case (op)
            OP_FLAG: begin
              if (byte_mode) begin
                emit      = 1'b1;
                emit_word = 16'(FLAG_BYTE);
                done      = 1'b1;
              end else begin
                part_req = 1'b1;
                part_one = (cnt != 4'd0) && (cnt != 4'd7);
                cnt_next = cnt + 4'd1;
                done     = (cnt == 4'd7);
              end
            end
            OP_DATA, OP_CRC: begin
              if (byte_mode) begin
                if (!esc_second) begin
                  emit = 1'b1;
                  if (cur_byte == FLAG_BYTE || cur_byte == ESC_BYTE) begin
                    emit_word       = 16'(ESC_BYTE);
                    esc_second_next = 1'b1;
                  end else begin
                    emit_word = 16'(cur_byte);
                    byte_done = 1'b1;
                  end
                end else begin
                  emit            = 1'b1;
                  emit_word       = 16'(cur_byte ^ ESC_XOR);
                  esc_second_next = 1'b0;
                  byte_done       = 1'b1;
                end
              end else if (stuff_pend) begin
                part_req        = 1'b1;
                part_one        = 1'b0;
                stuff_pend_next = 1'b0;
                byte_done       = (cnt == 4'd0);
              end else begin
                part_req = 1'b1;
                part_one = bit_val;
                cnt_next = cnt_m1;
                if (bit_val) begin
                  if (ones_inc == STUFF_RUN) begin
                    ones_run_next   = 3'd0;
                    stuff_pend_next = 1'b1;
                  end else begin
                    ones_run_next = ones_inc;
                  end
                end else begin
                  ones_run_next = 3'd0;
                end
                byte_done = (cnt_m1 == 4'd0) && !(bit_val && ones_inc == STUFF_RUN);
              end
              // Move on to the low CRC byte or finish
              if (byte_done) begin
                if (more) begin
                  cur_byte_next   = next_byte;
                  more_next       = 1'b0;
                  crc_reg_next    = crc_update(crc_reg, next_byte);
                  cnt_next        = 4'd8;
                  esc_second_next = 1'b0;
                end else begin
                  done = 1'b1;
                end
              end
            end
            OP_TAIL: begin
              if (cfg.line_mode == MODE_PULSE) begin
                if (held_valid) begin
                  emit            = 1'b1;
                  emit_word       = tail_sum[16] ? 16'hFFFF : tail_sum[15:0];
                  held_valid_next = 1'b0;
                end
              end else if (cfg.line_mode == MODE_SERIAL) begin
                if (bit_fill != 3'd0) begin
                  emit            = 1'b1;
                  emit_word       = 16'(pad_wide[7:0]);
                  shift_byte_next = pad_wide[7:0];
                  bit_fill_next   = 3'd0;
                end
              end
              done = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            state_next = ST_FLUSH;
          end
        end
      end

      // Release the final result of the request
      ST_FLUSH: begin
        if (adv) begin
          if (pend_valid) begin
            out_valid_next  = 1'b1;
            out_word_next   = pend_word;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Apply one line part
    if (part_req) begin
      if (cfg.line_mode == MODE_PULSE) begin
        if (held_valid) begin
          emit      = 1'b1;
          emit_word = 16'(held_pulse);
        end
        held_pulse_next = pulse_d;
        held_valid_next = 1'b1;
        remainder_next  = (remainder > pulse_cost) ? (remainder - pulse_cost) : 16'h0000;
      end else begin
        shift_byte_next = ser.shift;
        bit_fill_next   = ser.fill;
        if (ser.emit) begin
          emit      = 1'b1;
          emit_word = 16'(ser.bval);
        end
      end
    end

    // Push the older pending result out, keep the new one back
    if (emit) begin
      if (pend_valid) begin
        out_valid_next = 1'b1;
        out_word_next  = pend_word;
        out_last_next  = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_word_next  = emit_word;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      crc_reg    <= 16'h0000;
      ones_run   <= 3'd0;
      remainder  <= 16'h0000;
      held_pulse <= 6'd0;
      held_valid <= 1'b0;
      shift_byte <= 8'h00;
      bit_fill   <= 3'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      crc_reg    <= crc_reg_next;
      ones_run   <= ones_run_next;
      remainder  <= remainder_next;
      held_pulse <= held_pulse_next;
      held_valid <= held_valid_next;
      shift_byte <= shift_byte_next;
      bit_fill   <= bit_fill_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    op         <= op_next;
    cur_byte   <= cur_byte_next;
    next_byte  <= next_byte_next;
    more       <= more_next;
    cnt        <= cnt_next;
    stuff_pend <= stuff_pend_next;
    esc_second <= esc_second_next;
    pend_word  <= pend_word_next;
    out_word   <= out_word_next;
    out_last   <= out_last_next;
  end

  assign res_valid = out_valid;
  assign res.word  = out_word;
  assign res.last  = out_last;

endmodule

>>> rtl/rc_link_frame_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// rc_link_frame_line_encoder_unit: frame line encoder top level
// Turns framing requests and payload bytes into pulse durations, packed
// serial bytes or escaped bytes, with a running 16-bit CRC.
// ----------------------------------------------------------------------------
// The encoder takes one request per cycle, unless cmd_stall is raised, into
// a four-entry command queue and produces at most one result per cycle. The
// execution sequencer takes a command in ST_IDLE, steps through one line
// part or output byte at a time (a data byte in pulse or serial mode is
// 8 parts plus one per stuffed zero, a flag is 8 parts, a CRC request is two
// bytes, byte mode sends one or two bytes per data byte), and releases the
// final result in ST_FLUSH; start requests end in ST_IDLE. A stalled result
// port holds the sequencer; requests keep entering until the queue fills.
// Each result carries last on the final word a request caused; a request
// with no result gives no word. Configuration is written through cfg_we,
// cfg_index and cfg_data: index 0 line mode, index 1 period budget.
module rc_link_frame_line_encoder_unit import rlfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  in_item_t              cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res
);

  cfg_t cfg;
  logic q_push;
  cmd_t q_item;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_mode <= MODE_PULSE;
      cfg.period    <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_MODE: cfg.line_mode <= cfg_data[1:0];
        REG_PERIOD:    cfg.period    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  rlfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  rlfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  rlfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
